@@ sv/hsnte_pkg.sv @@
// Shared types and constants for the HDLC bit stuffing and NRZI tone encoder.
package hsnte_pkg;

    localparam logic [7:0] FLAG_BYTE   = 8'h7E;
    localparam logic [2:0] RUN_STUFF   = 3'd5;   // ones already sent before a stuffed zero
    localparam logic [2:0] LAST_BIT    = 3'd7;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       packet_end;
    } t_in_word;

    typedef struct packed {
        logic line_bit;
        logic tone_fast;
        logic stuffed;
        logic last;
    } t_out_word;

    typedef struct packed {
        logic load;   // capture the accepted word
        logic step;   // send one line bit into the output register
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;    // output register can take a bit this cycle
        logic final_bit;   // the bit under work is the last one of the byte
    } t_dp_status;

endpackage

@@ sv/hsnte_ctrl.sv @@
// Controller: sequences one byte at a time through the bit datapath.
module hsnte_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  hsnte_pkg::t_dp_status i_status,
    output hsnte_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_SEND
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd.load = 1'b0;
        o_cmd.step = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SEND;
                end
            end
            S_SEND: begin
                if (i_status.out_free) begin
                    o_cmd.step = 1'b1;
                    if (i_status.final_bit) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_final_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.step && i_status.final_bit) |=> (r_state == S_IDLE))
        else $error("controller did not return to idle after the last bit");

    a_load_step_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.load && o_cmd.step))
        else $error("load and step issued together");

    a_step_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.step |-> i_status.out_free)
        else $error("step issued with output register full");

endmodule

@@ sv/hsnte_dpath.sv @@
// Datapath: byte register, run counter, tone level and output register.
module hsnte_dpath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  hsnte_pkg::t_in_word   i_in_data,
    input  hsnte_pkg::t_dp_cmd    i_cmd,
    output hsnte_pkg::t_dp_status o_status,
    output logic                  o_valid,
    input  logic                  i_ready,
    output hsnte_pkg::t_out_word  o_out_data
);

    logic [7:0]           r_byte;
    logic                 r_flag;
    logic                 r_pkt_end;
    logic [2:0]           r_pos;
    logic [2:0]           r_ones_run;
    logic                 r_tone;
    logic                 r_out_valid;
    hsnte_pkg::t_out_word r_out;

    logic                 w_bit;
    logic                 w_run_full;
    logic                 w_stuff;
    logic                 w_flag_six;
    logic                 w_final;
    logic                 n_tone;
    logic [2:0]           n_ones_run;

    assign w_bit      = r_byte[r_pos];
    assign w_run_full = (r_ones_run >= hsnte_pkg::RUN_STUFF);
    assign w_stuff    = w_bit && w_run_full && !r_flag;
    assign w_flag_six = w_bit && w_run_full && r_flag;
    assign w_final    = (r_pos == hsnte_pkg::LAST_BIT) && !w_stuff;
    assign n_tone     = r_tone ^ (!w_bit || w_stuff);

    always_comb begin
        if (w_bit && !w_stuff && !w_flag_six) begin
            n_ones_run = r_ones_run + 3'd1;
        end else begin
            n_ones_run = '0;
        end
        // packet end restarts the run for the next packet
        if (w_final && r_pkt_end) begin
            n_ones_run = '0;
        end
    end

    assign o_status.out_free  = !r_out_valid || i_ready;
    assign o_status.final_bit = w_final;
    assign o_valid            = r_out_valid;
    assign o_out_data         = r_out;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_byte    <= i_in_data.data_byte;
            r_flag    <= (i_in_data.data_byte == hsnte_pkg::FLAG_BYTE);
            r_pkt_end <= i_in_data.packet_end;
        end
        if (i_cmd.step) begin
            r_out.line_bit  <= w_bit && !w_stuff;
            r_out.tone_fast <= n_tone;
            r_out.stuffed   <= w_stuff;
            r_out.last      <= w_final;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_ones_run  <= '0;
            r_tone      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_pos <= '0;
            end else if (i_cmd.step) begin
                // hold the position on a stuffed zero so the one follows it
                if (!w_stuff) begin
                    r_pos <= r_pos + 3'd1;
                end
                r_ones_run <= n_ones_run;
                r_tone     <= n_tone;
            end
            if (i_cmd.step) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_run_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ones_run <= hsnte_pkg::RUN_STUFF)
        else $error("ones run exceeded five");

    a_stuff_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.stuffed) |-> (!r_out.line_bit && !r_out.last))
        else $error("stuffed bit not a plain zero");

    a_nrzi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |=> (r_out.tone_fast == ($past(r_tone) ^ !r_out.line_bit)))
        else $error("tone level does not follow NRZI rule");

endmodule

@@ sv/hdlc_stuff_nrzi_tone_encoder_top.sv @@
// Top level of the HDLC bit stuffing and NRZI tone encoder.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------
//  input    | i_valid / o_ready  | i_in_data  (data_byte, packet_end)
//  output   | o_valid / i_ready  | o_out_data (line_bit, tone_fast, stuffed, last)
//
// One line bit leaves per cycle while the output register is taken; a byte gives 8 to 10
// bits, and a byte is first captured, then sent bit by bit before the next is accepted.
// The byte register and the single output register set that pace.
// Reset clears the run count, the tone level (1200 Hz) and the output register's valid flag.
// A stalled output holds the bit sequencer until the register is taken.
module hdlc_stuff_nrzi_tone_encoder_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  hsnte_pkg::t_in_word  i_in_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output hsnte_pkg::t_out_word o_out_data
);

    hsnte_pkg::t_dp_cmd    w_cmd;
    hsnte_pkg::t_dp_status w_status;

    hsnte_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    hsnte_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out_data (o_out_data)
    );

endmodule

@@ tb/sv/hsnte_stuff_checker.sv @@
// Checker for the HDLC stuffing encoder: predicts line bits per byte and compares them.
module hsnte_stuff_checker
    import hsnte_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_in_ready,
    input  t_in_word i_in_word,
    input  logic     i_out_valid,
    input  logic     i_out_ready,
    input  t_out_word i_out_word,
    output int       o_fail_count,
    output int       o_pending,
    output int       o_bytes,
    output int       o_bits,
    output int       o_stuffed_bits,
    output int       o_flag_bytes
);
    timeunit 1ns;
    timeprecision 1ps;

    t_out_word   line_bits_due[$];
    logic [2:0]  ones_run;
    logic        tone_level;

    // Stuff, NRZI-encode and queue every line bit that one byte produces.
    function automatic void predict_byte(input t_in_word w);
        int        pos;
        logic      data_bit;
        t_out_word b;
        pos = 0;
        while (pos < 8) begin
            data_bit = w.data_byte[pos];
            if (data_bit && ones_run == RUN_STUFF && w.data_byte != FLAG_BYTE) begin
                // insert a zero and hold the one for the next bit
                ones_run   = '0;
                tone_level = ~tone_level;
                b = '{line_bit: 1'b0, tone_fast: tone_level, stuffed: 1'b1, last: 1'b0};
                line_bits_due.push_back(b);
            end else begin
                if (data_bit) begin
                    ones_run = (ones_run == RUN_STUFF) ? 3'd0 : ones_run + 3'd1;
                end else begin
                    ones_run   = '0;
                    tone_level = ~tone_level;
                end
                b = '{line_bit: data_bit, tone_fast: tone_level, stuffed: 1'b0,
                      last: (pos == int'(LAST_BIT))};
                line_bits_due.push_back(b);
                pos++;
            end
        end
        if (w.packet_end) begin
            ones_run = '0;
        end
    endfunction

    function automatic void check_field(input string field, input logic exp_v,
                                        input logic got_v);
        if (got_v !== exp_v) begin
            $display("%0t: %s mismatch on line bit %0d: expected %b, got %b",
                     $time, field, o_bits, exp_v, got_v);
            o_fail_count++;
        end
    endfunction

    initial begin
        o_fail_count   = 0;
        o_pending      = 0;
        o_bytes        = 0;
        o_bits         = 0;
        o_stuffed_bits = 0;
        o_flag_bytes   = 0;
        ones_run       = '0;
        tone_level     = 1'b0;
    end

    always @(posedge i_clk) begin
        t_out_word exp_w;
        if (!i_rst_n) begin
            line_bits_due.delete();
            ones_run   = '0;
            tone_level = 1'b0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (line_bits_due.size() == 0) begin
                    $display("%0t: unexpected line bit, expected none, got %b",
                             $time, i_out_word);
                    o_fail_count++;
                end else begin
                    exp_w = line_bits_due.pop_front();
                    check_field("line_bit",  exp_w.line_bit,  i_out_word.line_bit);
                    check_field("tone_fast", exp_w.tone_fast, i_out_word.tone_fast);
                    check_field("stuffed",   exp_w.stuffed,   i_out_word.stuffed);
                    check_field("last",      exp_w.last,      i_out_word.last);
                    if (exp_w.stuffed) begin
                        o_stuffed_bits++;
                    end
                end
                o_bits++;
            end
            if (i_in_valid && i_in_ready) begin
                predict_byte(i_in_word);
                o_bytes++;
                if (i_in_word.data_byte == FLAG_BYTE) begin
                    o_flag_bytes++;
                end
            end
        end
        o_pending = line_bits_due.size();
    end

endmodule

@@ tb/sv/tb.sv @@
// Testbench top for the HDLC stuffing encoder: clock, reset, stimulus and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import hsnte_pkg::*;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_word  in_word;
    logic      out_valid;
    logic      out_ready;
    t_out_word out_word;

    int fails;
    int pending;
    int bytes_in;
    int bits_out;
    int stuffed_bits;
    int flag_bytes;
    int sent;
    bit steady;   // no idling on either side

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    hdlc_stuff_nrzi_tone_encoder_top i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_valid    (in_valid),
        .o_ready    (in_ready),
        .i_in_data  (in_word),
        .o_valid    (out_valid),
        .i_ready    (out_ready),
        .o_out_data (out_word)
    );

    hsnte_stuff_checker i_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_in_word      (in_word),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_out_word     (out_word),
        .o_fail_count   (fails),
        .o_pending      (pending),
        .o_bytes        (bytes_in),
        .o_bits         (bits_out),
        .o_stuffed_bits (stuffed_bits),
        .o_flag_bytes   (flag_bytes)
    );

    task automatic send_byte(input logic [7:0] data, input logic pkt_end);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_word  <= '{data_byte: data, packet_end: pkt_end};
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        sent++;
    endtask

    // Favor long runs of ones so stuffing happens often.
    function automatic logic [7:0] payload_byte();
        case ($urandom_range(0, 9))
            0, 1, 2: payload_byte = 8'hFF;
            3, 4:    payload_byte = 8'($urandom | $urandom);
            default: payload_byte = 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Receiver: random stalls per word, one long hold-off to back up the block.
    initial begin : receiver
        int gap;
        int taken;
        out_ready = 1'b0;
        taken = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (taken == 1200) begin
                out_ready <= 1'b0;
                repeat (400) @(posedge clk);
            end else begin
                gap = steady ? 0 : $urandom_range(0, 11);
                if (gap > 0) begin
                    out_ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            taken++;
        end
    end

    initial begin : watchdog
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin : stimulus
        int n;
        in_valid = 1'b0;
        in_word  = '0;
        rst_n    = 1'b0;
        sent     = 0;
        steady   = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);       // stuff inside the byte
        send_byte(8'hFF, 1'b0);       // carried run: two stuffed zeros, ten bits
        send_byte(FLAG_BYTE, 1'b0);   // flag: sixth one goes out unstuffed
        send_byte(FLAG_BYTE, 1'b1);
        send_byte(8'hF8, 1'b1);       // run of five, cleared by packet end
        send_byte(8'h01, 1'b0);       // no stuff after the clear
        send_byte(8'hF8, 1'b0);
        send_byte(8'h01, 1'b0);       // stuff before the first bit
        send_byte(8'h3F, 1'b0);
        send_byte(8'hFC, 1'b0);       // stuff right before the last bit
        send_byte(8'hF0, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(FLAG_BYTE, 1'b0);   // flag after a long run
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b1);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b1);

        while (sent < 400) begin
            steady = (sent >= 150 && sent < 220);
            if ($urandom_range(0, 99) < 85) begin
                // framed packet: opening flags, payload, closing flag
                n = $urandom_range(1, 3);
                repeat (n) send_byte(FLAG_BYTE, 1'b0);
                n = $urandom_range(1, 12);
                repeat (n) send_byte(payload_byte(), 1'b0);
                send_byte(FLAG_BYTE, 1'b1);
            end else begin
                n = $urandom_range(1, 4);
                repeat (n) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
        end
        steady = 1'b0;
        in_valid <= 1'b0;

        wait (bytes_in == sent && pending == 0);
        repeat (40) @(posedge clk);
        $display("Covered %0d bytes (%0d flags) giving %0d line bits, %0d stuffed zeros.",
                 bytes_in, flag_bytes, bits_out, stuffed_bits);
        $display("Included random stalls, a back-to-back stretch and one long output hold-off.");
        if (fails == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
